// ===== sv/slig_pkg.sv =====
`timescale 1ns / 1ps
// Package for the selection linear index generator: sizes, codes and shared types.
// Depends on nothing; every other file of the block imports it.
package slig_pkg;

    // Geometry
    localparam int MAX_DIMS    = 4;
    localparam int LIST_DEPTH  = 256;
    localparam int QUEUE_DEPTH = 2;

    // Field widths fixed by the interface
    localparam int CMD_W      = 2;
    localparam int DIM_W      = 2;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int INDEX_W    = 48;
    localparam int MODE_W     = 2;
    localparam int NDIMS_CFG_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Derived widths
    localparam int DIMX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NDIM_W   = $clog2(MAX_DIMS + 1);
    localparam int SLOT_W   = $clog2(LIST_DEPTH);
    localparam int LEN_W    = SLOT_W + 1;
    localparam int DIGIT_W  = SLOT_W + 1;
    localparam int ADDR_W   = DIMX_W + SLOT_W;
    localparam int MEM_DEPTH = MAX_DIMS * LIST_DEPTH;
    // exact index and size product never overflow these
    localparam int LIN_W    = COORD_W + SIZE_W * (MAX_DIMS - 1);
    localparam int PROD_W   = SIZE_W * MAX_DIMS;
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NEXT    = 2'd3
    } cmd_t;

    // Walk modes
    localparam logic [MODE_W-1:0] MODE_ALL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_LAST    = 3'd6;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_RESTART,
        OP_NEXT,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [DIMX_W-1:0]    dim;
        logic [COORD_W-1:0]   coord;
    } op_t;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [MODE_W-1:0]                  mode;
        logic [NDIM_W-1:0]                  ndims;
        logic [MAX_DIMS-1:0][SIZE_W-1:0]    sizes;
        logic [INDEX_W-1:0]                 last;
    } cfg_t;

endpackage

// ===== sv/slig_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and configuration writes.
// Depends on slig_pkg for field widths.
interface slig_in_if;
    import slig_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [DIM_W-1:0]   dim;
    logic [COORD_W-1:0] coord;

    modport source (output valid, output command, output dim, output coord, input ready);
    modport sink   (input valid, input command, input dim, input coord, output ready);
endinterface

interface slig_out_if;
    import slig_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] gen_index;
    logic               walk_done;
    logic               out_of_bounds;

    modport source (output valid, output gen_index, output walk_done, output out_of_bounds,
                    input ready);
    modport sink   (input valid, input gen_index, input walk_done, input out_of_bounds,
                    output ready);
endinterface

interface slig_cfg_if;
    import slig_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/selection_linear_index_generator.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle into a two-entry queue while it has room; the back end
// retires a clear, append, restart or all-mode next straight from idle, a point/selection
// next through a walk (one coordinate memory read and one multiply-accumulate per
// dimension, then bound test); a beat passes the front register, queue and result register.
// Reset: lists empty, walk restarted, registers at defaults; coordinate memory not cleared.
module selection_linear_index_generator (
    input  logic        clk,
    input  logic        rst_n,
    slig_in_if.sink     data_in,
    slig_out_if.source  data_out,
    slig_cfg_if.sink    cfg
);
    import slig_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]       mode_reg;
    logic [NDIMS_CFG_W-1:0]  num_dims_reg;
    logic [SIZE_W-1:0]       size_reg [MAX_DIMS];
    logic [INDEX_W-1:0]      last_reg;
    logic                    cfg_write;
    cfg_t                    cfg_bus;

    // Front-to-queue and queue-to-back links
    logic  push_valid;
    op_t   push_item;
    logic  push_ready;
    logic  op_valid;
    op_t   op_item;
    logic  op_pop;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ALL;
            num_dims_reg <= NDIMS_CFG_W'(1);
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                size_reg[i] <= SIZE_W'(1);
            end
            last_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg.index) inside
                CFG_SELECT_MODE: mode_reg     <= cfg.data[MODE_W-1:0];
                CFG_NUM_DIMS:    num_dims_reg <= cfg.data[NDIMS_CFG_W-1:0];
                CFG_DIM_SIZE_0, CFG_DIM_SIZE_1, CFG_DIM_SIZE_2, CFG_DIM_SIZE_3:
                    size_reg[DIMX_W'(cfg.index - CFG_DIM_SIZE_0)] <= cfg.data[SIZE_W-1:0];
                CFG_ALL_LAST:    last_reg     <= cfg.data[INDEX_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp the dimension count into 1..MAX_DIMS
    always_comb
    begin
        cfg_bus.mode = mode_reg;
        cfg_bus.last = last_reg;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            cfg_bus.sizes[i] = size_reg[i];
        end
        if (num_dims_reg == '0)
        begin
            cfg_bus.ndims = NDIM_W'(1);
        end
        else if (32'(num_dims_reg) > MAX_DIMS)
        begin
            cfg_bus.ndims = NDIM_W'(MAX_DIMS);
        end
        else
        begin
            cfg_bus.ndims = NDIM_W'(num_dims_reg);
        end
    end

    slig_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_in    (data_in),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    slig_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (op_valid),
        .pop_item   (op_item),
        .pop_ready  (op_pop)
    );

    slig_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_bus),
        .op_valid (op_valid),
        .op_item  (op_item),
        .op_pop   (op_pop),
        .data_out (data_out)
    );

endmodule

// ===== sv/slig_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input beats, decodes the command into an operation, registers it.
// Depends on slig_pkg and slig_in_if.
module slig_front (
    input  logic            clk,
    input  logic            rst_n,
    slig_in_if.sink         data_in,
    output logic            push_valid,
    output slig_pkg::op_t   push_item,
    input  logic            push_ready
);
    import slig_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    op_t      item_reg;
    op_t      item_next;
    op_t      decoded;
    logic     accept;

    // Classify the incoming beat
    always_comb
    begin
        decoded.dim   = DIMX_W'(data_in.dim);
        decoded.coord = data_in.coord;
        unique case (cmd_t'(data_in.command))
            CMD_CLEAR:   decoded.kind = OP_CLEAR;
            CMD_APPEND:  decoded.kind = (32'(data_in.dim) < MAX_DIMS) ? OP_APPEND : OP_NOP;
            CMD_RESTART: decoded.kind = OP_RESTART;
            CMD_NEXT:    decoded.kind = OP_NEXT;
            default:     decoded.kind = OP_NOP;
        endcase
    end

    assign data_in.ready = !valid_reg || push_ready;
    assign accept        = data_in.valid && data_in.ready;

    // Holding register in front of the queue
    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            item_next  = decoded;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// ===== sv/slig_queue.sv =====
`timescale 1ns / 1ps
// Short operation queue between front and back ends.
// Depends on slig_pkg for the operation type and depth.
module slig_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  slig_pkg::op_t   push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output slig_pkg::op_t   pop_item,
    input  logic            pop_ready
);
    import slig_pkg::*;

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg < QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/slig_back.sv =====
`timescale 1ns / 1ps
// Back end: coordinate lists, walk state, multiply-accumulate and result register.
// Depends on slig_pkg and slig_out_if.
module slig_back (
    input  logic            clk,
    input  logic            rst_n,
    input  slig_pkg::cfg_t  cfg,
    input  logic            op_valid,
    input  slig_pkg::op_t   op_item,
    output logic            op_pop,
    slig_out_if.source      data_out
);
    import slig_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FINISH
    } state_t;

    // Walk and list state
    state_t              state_reg,  state_next;
    logic [LEN_W-1:0]    len_reg    [MAX_DIMS];
    logic [LEN_W-1:0]    len_next   [MAX_DIMS];
    logic [DIGIT_W-1:0]  digit_reg  [MAX_DIMS];
    logic [DIGIT_W-1:0]  digit_next [MAX_DIMS];
    logic [INDEX_W-1:0]  flat_reg,   flat_next;
    logic                ended_reg,  ended_next;
    logic [DIMX_W-1:0]   step_reg,   step_next;
    logic [LIN_W-1:0]    lin_reg,    lin_next;
    logic [PROD_W-1:0]   prod_reg,   prod_next;
    logic                rd_ok_reg,  rd_ok_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_lin_reg,   out_lin_next;
    logic                out_done_reg,  out_done_next;
    logic                out_oob_reg,   out_oob_next;
    logic                out_free;

    // Coordinate memory
    logic [COORD_W-1:0]  coord_mem [MEM_DEPTH];
    logic [COORD_W-1:0]  rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic                rd_en;
    logic [DIMX_W-1:0]   rd_dim;
    logic [ADDR_W-1:0]   rd_addr;

    // Datapath
    logic [COORD_W-1:0]        coord_eff;
    logic [SIZE_W-1:0]         cur_size;
    logic [LIN_W+SIZE_W-1:0]   mul_lin;
    logic [PROD_W+SIZE_W-1:0]  mul_prod;
    logic [DIGIT_W-1:0]        adv_digit [MAX_DIMS];
    logic                      adv_end;

    assign out_free = !out_valid_reg || data_out.ready;
    assign rd_addr  = {rd_dim, digit_reg[rd_dim][SLOT_W-1:0]};

    // Multiply-accumulate: one dimension per cycle
    assign coord_eff = rd_ok_reg ? rd_data_reg : '0;
    assign cur_size  = cfg.sizes[step_reg];
    assign mul_lin   = {{SIZE_W{1'b0}}, lin_reg} * {{LIN_W{1'b0}}, cur_size};
    assign mul_prod  = {{SIZE_W{1'b0}}, prod_reg} * {{PROD_W{1'b0}}, cur_size};

    // Position advance: paired step in point mode, odometer otherwise
    always_comb
    begin
        logic carry;
        carry   = 1'b1;
        adv_end = 1'b0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            adv_digit[i] = digit_reg[i];
        end
        if (cfg.mode == MODE_POINT)
        begin
            if ({1'b0, digit_reg[0]} + 1'b1 >= {1'b0, len_reg[0]})
            begin
                adv_end = 1'b1;
            end
            else
            begin
                for (int i = 0; i < MAX_DIMS; i++)
                begin
                    if (NDIM_W'(i) < cfg.ndims)
                    begin
                        adv_digit[i] = digit_reg[i] + 1'b1;
                    end
                end
            end
        end
        else
        begin
            for (int i = MAX_DIMS - 1; i >= 0; i--)
            begin
                if (carry && NDIM_W'(i) < cfg.ndims)
                begin
                    if ({1'b0, digit_reg[i]} + 1'b1 < {1'b0, len_reg[i]})
                    begin
                        adv_digit[i] = digit_reg[i] + 1'b1;
                        carry        = 1'b0;
                    end
                    else if (i == 0)
                    begin
                        adv_end = 1'b1;
                    end
                    else
                    begin
                        adv_digit[i] = '0;
                    end
                end
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        digit_next = digit_reg;
        flat_next  = flat_reg;
        ended_next = ended_reg;
        step_next  = step_reg;
        lin_next   = lin_reg;
        prod_next  = prod_reg;
        rd_ok_next = rd_ok_reg;
        op_pop     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {op_item.dim, len_reg[op_item.dim][SLOT_W-1:0]};
        rd_en      = 1'b0;
        rd_dim     = '0;

        out_valid_next = out_valid_reg && !data_out.ready;
        out_lin_next   = out_lin_reg;
        out_done_next  = out_done_reg;
        out_oob_next   = out_oob_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid && out_free)
                begin
                    op_pop         = 1'b1;
                    out_valid_next = 1'b1;
                    out_lin_next   = '0;
                    out_done_next  = ended_reg;
                    out_oob_next   = 1'b0;
                    case (op_item.kind) inside
                        OP_CLEAR, OP_RESTART:
                        begin
                            if (op_item.kind == OP_CLEAR)
                            begin
                                for (int i = 0; i < MAX_DIMS; i++)
                                begin
                                    len_next[i] = '0;
                                end
                            end
                            for (int i = 0; i < MAX_DIMS; i++)
                            begin
                                digit_next[i] = '0;
                            end
                            flat_next     = '0;
                            ended_next    = 1'b0;
                            out_done_next = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (32'(len_reg[op_item.dim]) < LIST_DEPTH)
                            begin
                                mem_we                 = 1'b1;
                                len_next[op_item.dim]  = len_reg[op_item.dim] + 1'b1;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (ended_reg)
                            begin
                                out_oob_next = 1'b1;
                            end
                            else if (cfg.mode == MODE_ALL)
                            begin
                                out_lin_next = flat_reg;
                                out_oob_next = flat_reg > cfg.last;
                                if (flat_reg >= cfg.last)
                                begin
                                    ended_next    = 1'b1;
                                    out_done_next = 1'b1;
                                end
                                else
                                begin
                                    flat_next = flat_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                // start the per-dimension walk; result comes later
                                out_valid_next = 1'b0;
                                rd_en          = 1'b1;
                                rd_dim         = '0;
                                rd_ok_next     = digit_reg[0] < len_reg[0];
                                lin_next       = '0;
                                prod_next      = PROD_W'(1);
                                step_next      = '0;
                                state_next     = ST_MAC;
                            end
                        end
                        default:
                        begin
                            out_done_next = ended_reg;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                lin_next  = LIN_W'(mul_lin + (LIN_W + SIZE_W)'(coord_eff));
                prod_next = PROD_W'(mul_prod);
                if (NDIM_W'(step_reg) == cfg.ndims - NDIM_W'(1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_dim     = step_reg + 1'b1;
                    rd_ok_next = digit_reg[rd_dim] < len_reg[rd_dim];
                    step_next  = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    digit_next     = adv_digit;
                    ended_next     = adv_end;
                    out_valid_next = 1'b1;
                    out_lin_next   = INDEX_W'(lin_reg);
                    out_done_next  = adv_end;
                    out_oob_next   = PROD_W'(lin_reg) >= prod_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                len_reg[i]   <= '0;
                digit_reg[i] <= '0;
            end
            flat_reg      <= '0;
            ended_reg     <= 1'b0;
            step_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            digit_reg     <= digit_next;
            flat_reg      <= flat_next;
            ended_reg     <= ended_next;
            step_reg      <= step_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lin_reg      <= lin_next;
        prod_reg     <= prod_next;
        out_lin_reg  <= out_lin_next;
        out_done_reg <= out_done_next;
        out_oob_reg  <= out_oob_next;
    end

    // Coordinate memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coord_mem[mem_waddr] <= op_item.coord;
        end
        if (rd_en)
        begin
            rd_data_reg <= coord_mem[rd_addr];
        end
    end

    assign data_out.valid         = out_valid_reg;
    assign data_out.gen_index     = out_lin_reg;
    assign data_out.walk_done     = out_done_reg;
    assign data_out.out_of_bounds = out_oob_reg;

endmodule

// ===== test/tb_selection_linear_index_generator.sv =====
`timescale 1ns / 1ps
// Testbench for selection_linear_index_generator: directed and random walks in all, point and
// selection modes, checked beat by beat against a built-in index predictor.
// Depends on slig_pkg, the slig_*_if interfaces and the block itself.
module tb_selection_linear_index_generator;
    import slig_pkg::*;

    // Walk modes without a package constant
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

    // Cycles allowed for the pipe to settle
    localparam int IDLE_CYCLES = 8;
    localparam int END_CYCLES  = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [INDEX_W-1:0] lin;
        logic               done;
        logic               oob;
    } index_result_t;

    logic clk;
    logic rst_n;

    slig_in_if  in_if ();
    slig_out_if out_if ();
    slig_cfg_if cfg_if ();

    selection_linear_index_generator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .data_in  (in_if),
        .data_out (out_if),
        .cfg      (cfg_if)
    );

    // Predictor state
    logic [COORD_W-1:0] coord_mem [MAX_DIMS][LIST_DEPTH];
    int                 list_len [MAX_DIMS];
    int                 list_pos [MAX_DIMS];
    logic [INDEX_W-1:0] flat_cnt;
    bit                 walk_end;

    // Predictor copy of the registers
    logic [MODE_W-1:0]      cfg_mode;
    logic [NDIMS_CFG_W-1:0] cfg_ndims;
    logic [SIZE_W-1:0]      cfg_size [MAX_DIMS];
    logic [INDEX_W-1:0]     cfg_last;

    index_result_t expected_idx_q [$];
    int            mismatches;
    int            items_sent;
    int            hold_left;
    bit            in_gaps_on;
    bit            out_stall_on;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Index predictor
    // ---------------------------------------------------------------------
    function automatic void restart_walk();
        foreach (list_pos[i])
            list_pos[i] = 0;
        flat_cnt = '0;
        walk_end = 1'b0;
    endfunction

    function automatic void model_reset();
        foreach (list_len[i])
            list_len[i] = 0;
        restart_walk();
        cfg_mode  = MODE_ALL;
        cfg_ndims = 3'd1;
        foreach (cfg_size[i])
            cfg_size[i] = 13'd1;
        cfg_last  = '0;
    endfunction

    // Positions at or past the list end read as zero
    function automatic logic [63:0] coord_at(int d);
        if (list_pos[d] >= list_len[d])
            return 64'd0;
        return {52'd0, coord_mem[d][list_pos[d]]};
    endfunction

    // Point mode steps all digits together; otherwise odometer, innermost fastest
    function automatic void step_walk(int n);
        int i;
        if (cfg_mode == MODE_POINT)
        begin
            if (list_pos[0] + 1 >= list_len[0])
                walk_end = 1'b1;
            else
                for (i = 0; i < n; i++)
                    list_pos[i]++;
            return;
        end
        for (i = n - 1; i >= 0; i--)
        begin
            if (list_pos[i] + 1 < list_len[i])
            begin
                list_pos[i]++;
                return;
            end
            if (i == 0)
            begin
                walk_end = 1'b1;
                return;
            end
            list_pos[i] = 0;
        end
    endfunction

    function automatic index_result_t predict_index(cmd_t op, logic [DIM_W-1:0] d,
                                                    logic [COORD_W-1:0] c);
        index_result_t r;
        logic [63:0]   lin;
        logic [63:0]   prod;
        int            n;
        r    = '0;
        lin  = '0;
        prod = '0;
        case (op)
            CMD_CLEAR:
            begin
                foreach (list_len[i])
                    list_len[i] = 0;
                restart_walk();
            end
            CMD_APPEND:
            begin
                if (d < MAX_DIMS && list_len[d] < LIST_DEPTH)
                begin
                    coord_mem[d][list_len[d]] = c;
                    list_len[d]++;
                end
            end
            CMD_RESTART:
                restart_walk();
            default:
            begin
                if (walk_end)
                    r.oob = 1'b1;
                else if (cfg_mode == MODE_ALL)
                begin
                    lin   = {16'd0, flat_cnt};
                    r.oob = flat_cnt > cfg_last;
                    if (flat_cnt >= cfg_last)
                        walk_end = 1'b1;
                    else
                        flat_cnt = flat_cnt + 1'b1;
                end
                else
                begin
                    n = (cfg_ndims == 0) ? 1 : (cfg_ndims > MAX_DIMS) ? MAX_DIMS : cfg_ndims;
                    // exact multiply-accumulate, masked only on output
                    lin  = coord_at(0);
                    prod = {51'd0, cfg_size[0]};
                    for (int i = 1; i < n; i++)
                    begin
                        lin  = lin * cfg_size[i] + coord_at(i);
                        prod = prod * cfg_size[i];
                    end
                    r.oob = (prod == 0) || (lin > prod - 1);
                    step_walk(n);
                end
            end
        endcase
        r.lin  = lin[INDEX_W-1:0];
        r.done = walk_end;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Send one input beat; valid stays high for a following beat unless a gap is taken
    task automatic send_item(input cmd_t op, input logic [DIM_W-1:0] d,
                             input logic [COORD_W-1:0] c);
        index_result_t pred;
        if (in_gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= op;
        in_if.dim     <= d;
        in_if.coord   <= c;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        pred = predict_index(op, d, c);
        expected_idx_q = {expected_idx_q, pred};
        items_sent++;
    endtask

    // Let every outstanding result drain before touching registers
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_idx_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    // One register beat; caller lowers valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            CFG_SELECT_MODE: cfg_mode    = val[MODE_W-1:0];
            CFG_NUM_DIMS:    cfg_ndims   = val[NDIMS_CFG_W-1:0];
            CFG_DIM_SIZE_0:  cfg_size[0] = val[SIZE_W-1:0];
            CFG_DIM_SIZE_1:  cfg_size[1] = val[SIZE_W-1:0];
            CFG_DIM_SIZE_2:  cfg_size[2] = val[SIZE_W-1:0];
            CFG_DIM_SIZE_3:  cfg_size[3] = val[SIZE_W-1:0];
            CFG_ALL_LAST:    cfg_last    = val[INDEX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [MODE_W-1:0] mode, input logic [NDIMS_CFG_W-1:0] nd,
                                input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                                input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
                                input logic [INDEX_W-1:0] last);
        wait_idle();
        write_reg(CFG_SELECT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_NUM_DIMS, CFG_DATA_W'(nd));
        write_reg(CFG_DIM_SIZE_0, CFG_DATA_W'(s0));
        write_reg(CFG_DIM_SIZE_1, CFG_DATA_W'(s1));
        write_reg(CFG_DIM_SIZE_2, CFG_DATA_W'(s2));
        write_reg(CFG_DIM_SIZE_3, CFG_DATA_W'(s3));
        write_reg(CFG_ALL_LAST, CFG_DATA_W'(last));
        cfg_if.valid <= 1'b0;
    endtask

    // Result ready: long hold-off first, then random stall bursts
    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_if.ready <= 1'b0;
                stall_left--;
            end
            else if (out_stall_on && $urandom_range(0, 7) == 0)
            begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 9) - 1;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : result_checker
        index_result_t exp_r;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_idx_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result beat: index %0h done %0b oob %0b", $time,
                             out_if.gen_index, out_if.walk_done, out_if.out_of_bounds);
            end
            else
            begin
                exp_r = expected_idx_q.pop_front();
                if (out_if.gen_index !== exp_r.lin || out_if.walk_done !== exp_r.done ||
                    out_if.out_of_bounds !== exp_r.oob)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch: expected index %0h done %0b oob %0b, got %0h %0b %0b",
                                 $time, exp_r.lin, exp_r.done, exp_r.oob, out_if.gen_index,
                                 out_if.walk_done, out_if.out_of_bounds);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Random value helpers
    // ---------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] random_coord();
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 7));
    endfunction

    // Mostly small extents, now and then zero, the largest, or the 13-bit maximum
    function automatic logic [SIZE_W-1:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return 13'd0;
        if (pick < 8)
            return 13'd4096;
        if (pick < 11)
            return 13'd8191;
        return SIZE_W'($urandom_range(1, 8));
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Defaults: all mode with last index 0 ends on the first beat
    task automatic test_reset_defaults();
        send_item(CMD_NEXT, 2'd0, 12'd0);
        send_item(CMD_NEXT, 2'd3, 12'hFFF);
        send_item(CMD_RESTART, 2'd0, 12'd0);
        send_item(CMD_NEXT, 2'd0, 12'd0);
    endtask

    task automatic test_all_mode();
        set_geometry(MODE_ALL, 3'd1, 13'd1, 13'd1, 13'd1, 13'd1, 48'd2);
        repeat (4) send_item(CMD_NEXT, 2'd0, 12'd0);
        // largest last index never ends
        set_geometry(MODE_ALL, 3'd4, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 48'hFFFF_FFFF_FFFF);
        send_item(CMD_RESTART, 2'd0, 12'd0);
        send_item(CMD_NEXT, 2'd0, 12'd0);
    endtask

    // Paired coordinates at the extremes; dimension 2 left empty reads zero
    task automatic test_point_mode();
        set_geometry(MODE_POINT, 3'd4, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 48'd0);
        send_item(CMD_CLEAR, 2'd0, 12'd0);
        send_item(CMD_APPEND, 2'd0, 12'hFFF);
        send_item(CMD_APPEND, 2'd0, 12'd0);
        send_item(CMD_APPEND, 2'd1, 12'hFFF);
        send_item(CMD_APPEND, 2'd3, 12'd7);
        repeat (3) send_item(CMD_NEXT, 2'd0, 12'd0);
    endtask

    // Cross product, then a zero-size product, bad mode and bad dimension counts
    task automatic test_selection_mode();
        set_geometry(MODE_SELECT, 3'd2, 13'd3, 13'd4096, 13'd1, 13'd1, 48'd0);
        send_item(CMD_CLEAR, 2'd0, 12'd0);
        send_item(CMD_APPEND, 2'd0, 12'd2);
        send_item(CMD_APPEND, 2'd1, 12'hFFF);
        send_item(CMD_APPEND, 2'd1, 12'd0);
        repeat (3) send_item(CMD_NEXT, 2'd0, 12'd0);
        set_geometry(MODE_BAD, 3'd7, 13'd8191, 13'd0, 13'd1, 13'd1, 48'd0);
        send_item(CMD_RESTART, 2'd0, 12'd0);
        send_item(CMD_NEXT, 2'd0, 12'd0);
        set_geometry(MODE_SELECT, 3'd0, 13'd2, 13'd1, 13'd1, 13'd1, 48'd0);
        send_item(CMD_NEXT, 2'd0, 12'd0);
    endtask

    // Overfill one list, then walk it to the last position
    task automatic test_full_list();
        set_geometry(MODE_SELECT, 3'd3, 13'd4, 13'd1, 13'd4096, 13'd1, 48'd0);
        send_item(CMD_CLEAR, 2'($urandom), COORD_W'($urandom));
        send_item(CMD_APPEND, 2'd0, 12'd3);
        repeat (LIST_DEPTH + 3) send_item(CMD_APPEND, 2'd2, COORD_W'($urandom));
        while (!walk_end)
            send_item(CMD_NEXT, 2'($urandom), COORD_W'($urandom));
        send_item(CMD_NEXT, 2'd0, 12'd0);
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_input_backpressure();
        set_geometry(MODE_SELECT, 3'd2, 13'd5, 13'd5, 13'd1, 13'd1, 48'd0);
        send_item(CMD_CLEAR, 2'd0, 12'd0);
        for (int i = 0; i < 8; i++)
            send_item(CMD_APPEND, DIM_W'(i % 2), COORD_W'($urandom_range(0, 5)));
        hold_left = 150;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 13 == 12)
                send_item(CMD_RESTART, 2'd0, 12'd0);
            else
                send_item(CMD_NEXT, 2'd0, 12'd0);
        end
    endtask

    // Random geometry, fresh or reused lists, then a walk with some noise beats
    task automatic run_random_phase();
        logic [MODE_W-1:0]      mode;
        logic [NDIMS_CFG_W-1:0] nd;
        logic [INDEX_W-1:0]     last;
        int                     pick;
        int                     extra;
        pick = $urandom_range(0, 99);
        mode = (pick < 20) ? MODE_ALL : (pick < 55) ? MODE_POINT :
               (pick < 90) ? MODE_SELECT : MODE_BAD;
        pick = $urandom_range(0, 9);
        nd   = (pick == 0) ? 3'd0 : (pick == 1) ? 3'($urandom_range(5, 7)) :
               3'($urandom_range(1, 4));
        last = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)} :
               48'($urandom_range(0, 24));
        set_geometry(mode, nd, random_size(), random_size(), random_size(), random_size(), last);

        if ($urandom_range(0, 3) != 0)
        begin
            send_item(CMD_CLEAR, 2'($urandom), COORD_W'($urandom));
            repeat ($urandom_range(1, 14))
                send_item(CMD_APPEND, 2'($urandom), random_coord());
        end
        else
            send_item(CMD_RESTART, 2'($urandom), COORD_W'($urandom));

        // walk until a beat or two past the end, capped
        extra = $urandom_range(1, 2);
        for (int steps = 0; steps < 40 && extra > 0; steps++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(cmd_t'($urandom_range(0, 3)), 2'($urandom), COORD_W'($urandom));
            else
                send_item(CMD_NEXT, 2'($urandom), COORD_W'($urandom));
            if (walk_end)
                extra--;
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin : test_sequence
        in_if.valid   <= 1'b0;
        in_if.command <= CMD_CLEAR;
        in_if.dim     <= '0;
        in_if.coord   <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_SELECT_MODE;
        cfg_if.data   <= '0;
        rst_n         <= 1'b0;
        mismatches   = 0;
        items_sent   = 0;
        hold_left    = 0;
        in_gaps_on   = 1'b1;
        out_stall_on = 1'b1;
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_all_mode();
        test_point_mode();
        test_selection_mode();
        test_full_list();
        test_input_backpressure();
        while (items_sent < 560)
            run_random_phase();

        // closing stretch with no idling on either side
        in_gaps_on   = 1'b0;
        out_stall_on = 1'b0;
        repeat (3) run_random_phase();

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_idx_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/slig_pkg.sv
sv/slig_if.sv
sv/slig_front.sv
sv/slig_queue.sv
sv/slig_back.sv
sv/selection_linear_index_generator.sv
test/tb_selection_linear_index_generator.sv
